// ===== hdl/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsr_pkg: shared definitions for the bounded stack with prefix reverse
// Operation and status codes, default depth and the result bundle that
// passes from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package bsr_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W        = 32;
   localparam int FREE_W        = 5;

   // operation codes
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_MIDDLE = 2'd2;
   localparam logic [1:0] OP_REV    = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FEW   = 2'd3;

   typedef struct packed {
      logic signed [WORD_W-1:0] data_out;
      logic [1:0]               status;
      logic [FREE_W-1:0]        free_slots;
   } res_type;

endpackage

// ===== hdl/bsr_mem.sv =====
// ----------------------------------------------------------------------------
// bsr_mem: stack storage
// One write port and two read ports; read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module bsr_mem
   import bsr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic signed [WORD_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr_a,
   input  logic [AW-1:0]            rd_addr_b,
   output logic signed [WORD_W-1:0] rd_data_a,
   output logic signed [WORD_W-1:0] rd_data_b
);

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_a_ff;
   logic signed [WORD_W-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/bsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsr_ctrl: operation sequencer
// Takes one request word at a time, drives the storage ports and steps the
// shared index unit (lo/hi counters and their compare) through the swaps
// of a bottom-half reverse. Holds the result until the output stage takes it.
// ----------------------------------------------------------------------------
module bsr_ctrl
   import bsr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_operation,
   input  logic signed [WORD_W-1:0] req_push_value,
   output logic                     mem_wr_en,
   output logic [AW-1:0]            mem_wr_addr,
   output logic signed [WORD_W-1:0] mem_wr_data,
   output logic                     mem_rd_en,
   output logic [AW-1:0]            mem_rd_addr_a,
   output logic [AW-1:0]            mem_rd_addr_b,
   input  logic signed [WORD_W-1:0] mem_rd_data_a,
   input  logic signed [WORD_W-1:0] mem_rd_data_b,
   output logic                     res_valid,
   output res_type                  res,
   input  logic                     res_take
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_SW_RD  = 3'd3;
   localparam logic [2:0] S_SW_WLO = 3'd4;
   localparam logic [2:0] S_SW_WHI = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]               state_ff, state_in;
   logic [1:0]               op_ff, op_in;
   logic signed [WORD_W-1:0] val_ff, val_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            lo_ff, lo_in;
   logic [AW-1:0]            hi_ff, hi_in;
   logic signed [WORD_W-1:0] data_ff, data_in;
   logic [1:0]               status_ff, status_in;

   logic                     accept;
   logic [CW-1:0]            cnt_m1;
   logic [AW-1:0]            mid_idx;
   logic [AW-1:0]            lo_nx;
   logic [AW-1:0]            hi_nx;
   logic [31:0]              free_full;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // shared index unit
   assign cnt_m1  = count_ff - CW'(1);
   assign mid_idx = AW'(cnt_m1 >> 1);
   assign lo_nx   = lo_ff + AW'(1);
   assign hi_nx   = hi_ff - AW'(1);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      data_in       = data_ff;
      status_in     = status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = lo_ff;
      mem_wr_data   = mem_rd_data_b;
      mem_rd_en     = 1'b0;
      mem_rd_addr_a = lo_ff;
      mem_rd_addr_b = hi_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               val_in   = req_push_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            data_in   = '0;
            status_in = ST_OK;
            case (op_ff)
               OP_PUSH: begin
                  if (count_ff == CW'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AW'(count_ff);
                     mem_wr_data = val_ff;
                     count_in    = count_ff + CW'(1);
                  end
                  state_in = S_DONE;
               end
               OP_POP: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     mem_rd_en     = 1'b1;
                     mem_rd_addr_a = AW'(cnt_m1);
                     count_in      = cnt_m1;
                     state_in      = S_RDWAIT;
                  end
               end
               OP_MIDDLE: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     mem_rd_en     = 1'b1;
                     mem_rd_addr_a = mid_idx;
                     state_in      = S_RDWAIT;
                  end
               end
               default: begin
                  lo_in = '0;
                  hi_in = mid_idx;
                  if (count_ff < CW'(2)) begin
                     status_in = ST_FEW;
                     state_in  = S_DONE;
                  end else if (mid_idx == '0) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SW_RD;
                  end
               end
            endcase
         end
         S_RDWAIT: begin
            data_in  = mem_rd_data_a;
            state_in = S_DONE;
         end
         S_SW_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_SW_WLO;
         end
         S_SW_WLO: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = lo_ff;
            mem_wr_data = mem_rd_data_b;
            state_in    = S_SW_WHI;
         end
         S_SW_WHI: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = hi_ff;
            mem_wr_data = mem_rd_data_a;
            lo_in       = lo_nx;
            hi_in       = hi_nx;
            state_in    = (lo_nx < hi_nx) ? S_SW_RD : S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      val_ff    <= val_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      data_ff   <= data_in;
      status_ff <= status_in;
   end

   // result word
   assign free_full      = 32'(DEPTH) - 32'(count_ff);
   assign res_valid      = (state_ff == S_DONE);
   assign res.data_out   = data_ff;
   assign res.status     = status_ff;
   assign res.free_slots = free_full[FREE_W-1:0];

   // checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted word did not start execution");

   a_swap_order : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SW_WLO) |-> (lo_ff < hi_ff))
      else $error("swap indices crossed");

   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && op_ff == OP_POP && count_ff != '0)
      |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("pop did not decrement fill count");

   a_rev_keeps_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SW_WHI) |=> $stable(count_ff))
      else $error("fill count moved during reverse");

endmodule

// ===== hdl/bounded_stack_with_prefix_reverse.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_prefix_reverse: bounded stack with bottom-half reverse
// Top level: storage, sequencer and the registered response stage.
// ----------------------------------------------------------------------------
// One request word is worked at a time; req_stall is high from acceptance
// until the sequencer has handed its response to the output register.
// Push and refused operations go from execution straight to the response;
// pop and middle add one registered read of the storage, and reverse adds
// a swap of floor((count+1)/4) pairs. The sequencer returns to idle before
// the next request can be accepted. The swap cost is set by the single
// write port: each pair is one dual read followed by two writes, stepped by
// one shared lo/hi index unit. The response register lets the next request
// be accepted while a response still waits on rsp_stall.
// ----------------------------------------------------------------------------
module bounded_stack_with_prefix_reverse
   import bsr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_operation,
   input  logic signed [WORD_W-1:0] req_push_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WORD_W-1:0] rsp_data_out,
   output logic [1:0]               rsp_status,
   output logic [FREE_W-1:0]        rsp_free_slots
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic                     mem_wr_en;
   logic [AW-1:0]            mem_wr_addr;
   logic signed [WORD_W-1:0] mem_wr_data;
   logic                     mem_rd_en;
   logic [AW-1:0]            mem_rd_addr_a;
   logic [AW-1:0]            mem_rd_addr_b;
   logic signed [WORD_W-1:0] mem_rd_data_a;
   logic signed [WORD_W-1:0] mem_rd_data_b;
   logic                     res_valid;
   res_type                  res;
   logic                     res_take;

   logic                     rsp_valid_ff, rsp_valid_in;
   res_type                  rsp_ff;

   bsr_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_en     (mem_rd_en),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_data_a),
      .rd_data_b (mem_rd_data_b)
   );

   bsr_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_push_value (req_push_value),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr_a  (mem_rd_addr_a),
      .mem_rd_addr_b  (mem_rd_addr_b),
      .mem_rd_data_a  (mem_rd_data_a),
      .mem_rd_data_b  (mem_rd_data_b),
      .res_valid      (res_valid),
      .res            (res),
      .res_take       (res_take)
   );

   // response register: load when empty or draining
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = rsp_ff.data_out;
   assign rsp_status     = rsp_ff.status;
   assign rsp_free_slots = rsp_ff.free_slots;

endmodule

// ===== dv/bounded_stack_with_prefix_reverse_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_prefix_reverse_tb: self-checking bench for the stack
// Sends push, pop, middle and reverse words over the request channel and
// checks every response against a shadow stack kept in the bench. Directed
// corner cases come first, then a fill and drain to both bounds, then long
// random runs under several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module bounded_stack_with_prefix_reverse_tb;
   import bsr_pkg::*;

   localparam int DEPTH         = DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASE_WORDS   = 450;

   typedef struct {
      logic signed [WORD_W-1:0] data;
      logic [1:0]               status;
      logic [FREE_W-1:0]        free;
   } stack_result_type;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_operation  = OP_PUSH;
   logic signed [WORD_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic signed [WORD_W-1:0] rsp_data_out;
   logic [1:0]               rsp_status;
   logic [FREE_W-1:0]        rsp_free_slots;

   // shadow copy of the stack contents, bottom at index 0
   logic signed [WORD_W-1:0] shadow_words [DEPTH];
   int unsigned              shadow_fill = 0;
   stack_result_type         pending_results [$];

   int error_count   = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int op_seen [4]     = '{default: 0};
   int status_seen [4] = '{default: 0};

   always #6 clock = ~clock;

   bounded_stack_with_prefix_reverse #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_free_slots (rsp_free_slots)
   );

   // apply one accepted word to the shadow stack and queue its response
   function automatic void stack_apply(input logic [1:0] op,
                                       input logic signed [WORD_W-1:0] value);
      stack_result_type         r;
      int unsigned              lo;
      int unsigned              hi;
      logic signed [WORD_W-1:0] t;
      r.data   = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_words[shadow_fill] = value;
               shadow_fill++;
            end
         end
         OP_POP: begin
            if (shadow_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               shadow_fill--;
               r.data = shadow_words[shadow_fill];
            end
         end
         OP_MIDDLE: begin
            if (shadow_fill == 0) r.status = ST_EMPTY;
            else r.data = shadow_words[(shadow_fill - 1) / 2];
         end
         default: begin
            // reverse: bottom half reversed by pairwise swaps
            if (shadow_fill < 2) begin
               r.status = ST_FEW;
            end else begin
               lo = 0;
               hi = (shadow_fill - 1) / 2;
               while (lo < hi) begin
                  t                = shadow_words[lo];
                  shadow_words[lo] = shadow_words[hi];
                  shadow_words[hi] = t;
                  lo++;
                  hi--;
               end
            end
         end
      endcase
      r.free = FREE_W'(DEPTH - shadow_fill);
      pending_results.push_back(r);
      op_seen[op]++;
      status_seen[r.status]++;
   endfunction

   task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                  input logic signed [63:0] want);
      $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // send one request word, with random gaps, and wait for its acceptance
   task automatic send_word(input logic [1:0] op, input logic signed [WORD_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_push_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      stack_apply(op, value);
      words_sent++;
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response word with none outstanding, status", rsp_status, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data_out !== want.data)
               report_mismatch("data_out", rsp_data_out, want.data);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_free_slots !== want.free)
               report_mismatch("free_slots", rsp_free_slots, want.free);
            words_checked++;
         end
      end
   end

   // push values lean on the extremes now and then
   function automatic logic signed [WORD_W-1:0] random_value();
      case ($urandom_range(7))
         0: return {1'b1, {(WORD_W-1){1'b0}}};
         1: return {1'b0, {(WORD_W-1){1'b1}}};
         2: return WORD_W'($urandom_range(8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   // empty stack, single entry, two entries and four entries, with the value extremes
   task automatic test_small_stack();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_word(OP_POP, random_value());
      send_word(OP_MIDDLE, random_value());
      send_word(OP_REV, random_value());
      send_word(OP_PUSH, {1'b1, {(WORD_W-1){1'b0}}});
      send_word(OP_REV, random_value());
      send_word(OP_MIDDLE, random_value());
      send_word(OP_POP, random_value());
      send_word(OP_PUSH, {1'b0, {(WORD_W-1){1'b1}}});
      send_word(OP_PUSH, '1);
      send_word(OP_REV, random_value());
      send_word(OP_MIDDLE, random_value());
      send_word(OP_PUSH, '0);
      send_word(OP_PUSH, 32'sd5);
      send_word(OP_REV, random_value());
      send_word(OP_MIDDLE, random_value());
      repeat (4) send_word(OP_POP, random_value());
      send_word(OP_POP, random_value());
   endtask

   // fill to the bound, overflow it, reverse a full stack, then drain past empty
   task automatic test_fill_and_drain();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (DEPTH) send_word(OP_PUSH, random_value());
      send_word(OP_PUSH, random_value());
      send_word(OP_MIDDLE, random_value());
      send_word(OP_REV, random_value());
      send_word(OP_MIDDLE, random_value());
      send_word(OP_PUSH, random_value());
      repeat (DEPTH + 1) send_word(OP_POP, random_value());
   endtask

   // random words; the depth sweeps between empty and full so both bounds recur
   task automatic test_random_phase(input int words, input int idle_pct, input int stall_pct);
      bit         filling;
      int         roll;
      logic [1:0] op;
      filling       = 1'b1;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (words) begin
         if (shadow_fill == DEPTH) filling = 1'b0;
         else if (shadow_fill == 0) filling = 1'b1;
         else if ($urandom_range(99) < 4) filling = ~filling;
         roll = $urandom_range(99);
         if (roll < 10) op = OP_MIDDLE;
         else if (roll < 24) op = OP_REV;
         else if (roll < 78) op = filling ? OP_PUSH : OP_POP;
         else op = filling ? OP_POP : OP_PUSH;
         send_word(op, random_value());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_small_stack();
      test_fill_and_drain();
      test_random_phase(PHASE_WORDS, 0, 0);
      test_random_phase(PHASE_WORDS, 73, 0);
      test_random_phase(PHASE_WORDS, 0, 73);
      test_random_phase(PHASE_WORDS, 22, 22);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d request words, %0d responses checked",
               words_sent, words_checked);
      $display("push/pop/middle/rev %0d/%0d/%0d/%0d; ok/full/empty/few %0d/%0d/%0d/%0d",
               op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_MIDDLE], op_seen[OP_REV],
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
               status_seen[ST_FEW]);
      if (error_count == 0) begin
         $display("bounded_stack_with_prefix_reverse_tb: clean");
      end else begin
         $display("bounded_stack_with_prefix_reverse_tb: errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("Timeout with %0d responses outstanding", pending_results.size());
      $display("bounded_stack_with_prefix_reverse_tb: errors");
      $finish;
   end

endmodule
